>>> rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the Taylor sine/cosine pipeline: number
// formats, the lane record that moves down the cell chain, and the signed
// Q56 reciprocal-factorial coefficients of both series.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int XW      = 32;  // angle and result width, Q2.29
	localparam int YW      = 63;  // x*x, unsigned Q5.58
	localparam int HW      = 62;  // Horner accumulator, signed Q56
	localparam int MW      = 61;  // magnitude bits of the accumulator
	localparam int N_CELLS = 8;   // Horner steps in the chain

	typedef logic signed [HW-1:0] coef_t;

	// Item as it travels from cell to cell.
	typedef struct packed {
		logic                 mode;
		logic signed [XW-1:0] x;
		logic [YW-1:0]        y;
		coef_t                h;
	} lane_t;

	localparam logic [63:0] ONE = 64'd1 << 56;

	// (-1)^k / (2k+1)!, magnitude rounded to nearest with ties up
	localparam coef_t SIN_COEF [N_CELLS] = '{
		 coef_t'(ONE),
		-coef_t'((ONE + 64'd3) / 64'd6),
		 coef_t'((ONE + 64'd60) / 64'd120),
		-coef_t'((ONE + 64'd2520) / 64'd5040),
		 coef_t'((ONE + 64'd181440) / 64'd362880),
		-coef_t'((ONE + 64'd19958400) / 64'd39916800),
		 coef_t'((ONE + 64'd3113510400) / 64'd6227020800),
		-coef_t'((ONE + 64'd653837184000) / 64'd1307674368000)
	};

	// (-1)^k / (2k)!
	localparam coef_t COS_COEF [N_CELLS+1] = '{
		 coef_t'(ONE),
		-coef_t'((ONE + 64'd1) / 64'd2),
		 coef_t'((ONE + 64'd12) / 64'd24),
		-coef_t'((ONE + 64'd360) / 64'd720),
		 coef_t'((ONE + 64'd20160) / 64'd40320),
		-coef_t'((ONE + 64'd1814400) / 64'd3628800),
		 coef_t'((ONE + 64'd239500800) / 64'd479001600),
		-coef_t'((ONE + 64'd43589145600) / 64'd87178291200),
		 coef_t'((ONE + 64'd10461394944000) / 64'd20922789888000)
	};

endpackage

>>> rtl/tsc_in_if.sv
// ----------------------------------------------------------------------------
// tsc_in_if
// Angle channel: valid/ready handshake with mode bit and Q2.29 angle.
// ----------------------------------------------------------------------------
interface tsc_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [31:0] angle;

	modport source(output valid, mode, angle, input ready);
	modport sink(input valid, mode, angle, output ready);
endinterface

>>> rtl/tsc_out_if.sv
// ----------------------------------------------------------------------------
// tsc_out_if
// Result channel: valid/ready handshake with the saturated Q2.29 value.
// ----------------------------------------------------------------------------
interface tsc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;

	modport source(output valid, value, input ready);
	modport sink(input valid, value, output ready);
endinterface

>>> rtl/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// Entry stage: square the angle and seed the Horner accumulator.
// ----------------------------------------------------------------------------
module tsc_front import tsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic                 mode,
	input  logic signed [XW-1:0] angle,
	output logic                 valid_out,
	output lane_t                lane_out
);

	logic signed [2*XW-1:0] sq;

	assign sq = angle * angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	// sine starts from zero so its first cell just loads the top coefficient
	always_ff @(posedge clk) begin
		if (en) begin
			lane_out.mode <= mode;
			lane_out.x    <= angle;
			lane_out.y    <= sq[YW-1:0];
			lane_out.h    <= mode ? COS_COEF[N_CELLS] : '0;
		end
	end

endmodule

>>> rtl/tsc_cell.sv
// ----------------------------------------------------------------------------
// tsc_cell
// One Horner step, h = a_k + round(h * y / 2^58), in three stages:
// partial products, rounded sum, signed add of the coefficient.
// ----------------------------------------------------------------------------
module tsc_cell import tsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  coef_t coef_sin,
	input  coef_t coef_cos,
	input  logic  valid_in,
	input  lane_t lane_in,
	output logic  valid_out,
	output lane_t lane_out
);

	logic [MW-1:0] habs;
	logic [124:0]  acc;
	coef_t         term;

	lane_t         lane_s1, lane_s2;
	logic          valid_s1, valid_s2;
	logic          neg_s1, neg_s2;
	logic [63:0]   p00_s1;
	logic [62:0]   p01_s1;
	logic [60:0]   p10_s1;
	logic [59:0]   p11_s1;
	logic [HW-1:0] mag_s2;

	// y is never negative, so the sign of the product is the sign of h
	assign habs = lane_in.h[HW-1] ? MW'(-lane_in.h) : MW'(lane_in.h);

	assign acc = 125'(p00_s1) + (125'(p01_s1) << 32) + (125'(p10_s1) << 32)
		+ (125'(p11_s1) << 64) + (125'(1) << 57);

	assign term = neg_s2 ? -coef_t'(mag_s2) : coef_t'(mag_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_out <= 1'b0;
		end else if (en) begin
			valid_s1  <= valid_in;
			valid_s2  <= valid_s1;
			valid_out <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= lane_in;
			neg_s1  <= lane_in.h[HW-1];
			p00_s1  <= 64'(habs[31:0]) * 64'(lane_in.y[31:0]);
			p01_s1  <= 63'(habs[31:0]) * 63'(lane_in.y[YW-1:32]);
			p10_s1  <= 61'(habs[MW-1:32]) * 61'(lane_in.y[31:0]);
			p11_s1  <= 60'(habs[MW-1:32]) * 60'(lane_in.y[YW-1:32]);

			// |h*y| stays far below 2^119, so the rounded magnitude fits HW bits
			lane_s2 <= lane_s1;
			neg_s2  <= neg_s1;
			mag_s2  <= acc[119:58];

			lane_out.mode <= lane_s2.mode;
			lane_out.x    <= lane_s2.x;
			lane_out.y    <= lane_s2.y;
			lane_out.h    <= (lane_s2.mode ? coef_cos : coef_sin) + term;
		end
	end

endmodule

>>> rtl/tsc_finish.sv
// ----------------------------------------------------------------------------
// tsc_finish
// Final scaling: sine takes round(x*h / 2^56), cosine round(h / 2^27)
// (as h * 2^29 on the same multiplier), then saturates to Q2.29.
// ----------------------------------------------------------------------------
module tsc_finish import tsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  lane_t                lane_in,
	output logic                 valid_out,
	output logic signed [XW-1:0] value
);

	localparam int MAGW = 38;

	logic [MW-1:0]   habs;
	logic [XW-1:0]   mult;
	logic [93:0]     acc;
	logic            neg;

	logic            valid_s1, valid_s2;
	logic            neg_s1, neg_s2;
	logic [63:0]     p0_s1;
	logic [60:0]     p1_s1;
	logic [MAGW-1:0] mag_s2;

	assign habs = lane_in.h[HW-1] ? MW'(-lane_in.h) : MW'(lane_in.h);
	// magnitude of -4 wraps to 0x80000000, which is exactly 2^31 unsigned
	assign mult = lane_in.mode ? (XW'(1) << 29)
		: (lane_in.x[XW-1] ? XW'(-lane_in.x) : XW'(lane_in.x));
	assign neg  = lane_in.h[HW-1] ^ (!lane_in.mode & lane_in.x[XW-1]);
	assign acc  = 94'(p0_s1) + (94'(p1_s1) << 32) + (94'(1) << 55);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_out <= 1'b0;
		end else if (en) begin
			valid_s1  <= valid_in;
			valid_s2  <= valid_s1;
			valid_out <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg;
			p0_s1  <= 64'(mult) * 64'(habs[31:0]);
			p1_s1  <= 61'(mult) * 61'(habs[MW-1:32]);

			neg_s2 <= neg_s1;
			mag_s2 <= acc[93:56];

			if (neg_s2) begin
				value <= (mag_s2 > MAGW'(64'h8000_0000)) ? XW'(64'h8000_0000)
					: -XW'(mag_s2);
			end else begin
				value <= (mag_s2 > MAGW'(64'h7FFF_FFFF)) ? XW'(64'h7FFF_FFFF)
					: XW'(mag_s2);
			end
		end
	end

endmodule

>>> rtl/taylor_sine_cosine_top.sv
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top
// Taylor-series sine (odd terms through x^15) or cosine (even terms through
// x^16) of a Q2.29 angle, evaluated by Horner's rule in y = x^2 on a chain
// of eight identical multiply-add cells, result saturated to Q2.29.
//
//   channel | dir | payload                       | handshake
//   --------+-----+-------------------------------+-------------
//   sample  | in  | mode (0 sin, 1 cos), angle    | valid/ready
//   result  | out | value                         | valid/ready
//
// One transfer per cycle in each direction when the result side keeps up.
// The pipeline has one square stage, three stages in each of the
// eight Horner cells (32x32 partial products, rounded sum, coefficient add)
// and three finishing stages ending in the result register.
// A stall on the result side freezes the whole chain; sample.ready drops only
// while a finished result waits in the output register.
// Reset clears the valid bits only; the chain starts empty.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_top import tsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tsc_in_if.sink      sample,
	tsc_out_if.source   result
);

	logic  en;
	logic  vld  [N_CELLS+1];
	lane_t lane [N_CELLS+1];

	// advance everything unless the output register holds an untaken result
	assign en           = !result.valid || result.ready;
	assign sample.ready = en;

	tsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (sample.valid),
		.mode      (sample.mode),
		.angle     (sample.angle),
		.valid_out (vld[0]),
		.lane_out  (lane[0])
	);

	// cell i applies coefficient index N_CELLS-1-i, highest order first
	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		tsc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.coef_sin  (SIN_COEF[N_CELLS-1-i]),
			.coef_cos  (COS_COEF[N_CELLS-1-i]),
			.valid_in  (vld[i]),
			.lane_in   (lane[i]),
			.valid_out (vld[i+1]),
			.lane_out  (lane[i+1])
		);
	end

	tsc_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (vld[N_CELLS]),
		.lane_in   (lane[N_CELLS]),
		.valid_out (result.valid),
		.value     (result.value)
	);

endmodule

>>> rtl/tsc_checker.sv
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks of the sine/cosine pipeline: stall behavior of the
// output register and how input ready follows the result side.
// ----------------------------------------------------------------------------
module tsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_value
);

	// a stalled result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("result changed while stalled");

	// an empty output register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output register");

	// a stalled result freezes the chain, so no new sample enters
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("sample taken while result stalled");

	// with ready forced by a free output register, a valid sample is taken
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> in_ready)
		else $error("valid sample not taken");

endmodule

bind taylor_sine_cosine_top tsc_checker u_tsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_value (result.value)
);

>>> dv/taylor_sine_cosine_top_test.sv
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top_test
// Streams angles in both modes through the Taylor sine/cosine pipeline and
// compares every result against a bit-exact fixed-point Horner evaluation
// kept in the bench, under random idling on both channels and one long
// back-to-back stretch.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tsc_pkg::*;

	localparam logic MODE_SIN = 1'b0;
	localparam logic MODE_COS = 1'b1;

	localparam int PIPE_LATENCY = 28;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 23;

	// Fixed-point formats of the series evaluation.
	localparam int COEF_FRAC = 56;
	localparam int SQ_FRAC   = 58;
	localparam int OUT_FRAC  = 29;

	localparam longint OUT_MAX = 64'sd2147483647;
	localparam longint OUT_MIN = -64'sd2147483648;

	logic clk;
	logic arst_n;

	tsc_in_if  sample();
	tsc_out_if result();

	taylor_sine_cosine_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result)
	);

	// Values still owed by the pipeline, oldest first.
	logic signed [XW-1:0] pending_values [$];

	int  mismatches;
	int  cycles;
	bit  steady;  // suppress idling on both channels

	// ------------------------------------------------------------------------
	// Fixed-point series evaluation
	// ------------------------------------------------------------------------

	function automatic longint unsigned factorial(int n);
		longint unsigned f;
		f = 1;
		for (int i = 2; i <= n; i++)
			f = f * i;
		return f;
	endfunction

	// round(a*b / 2^s), ties away from zero; magnitude clamped at 2^63-1
	// after dropping bits above 64, as a 64-bit datapath would.
	function automatic longint scaled_product(longint a, longint b, int s);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] prod;
		logic [127:0] shifted;
		logic [63:0]  mag;
		bit           neg;
		neg     = (a < 0) != (b < 0);
		ua      = (a < 0) ? 64'd0 - a : a;
		ub      = (b < 0) ? 64'd0 - b : b;
		prod    = {64'd0, ua} * {64'd0, ub};
		shifted = (prod + (128'd1 << (s - 1))) >> s;
		mag     = shifted[63:0];
		if (mag[63])
			mag = 64'h7FFF_FFFF_FFFF_FFFF;
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	// k-th Horner coefficient, (-1)^k / d rounded to Q56 with ties up,
	// where d is (2k+1)! for sine and (2k)! for cosine.
	function automatic longint series_coef(logic mode, int k);
		longint unsigned d;
		longint unsigned q;
		d = factorial((mode == MODE_COS) ? 2 * k : 2 * k + 1);
		q = ((64'd1 << COEF_FRAC) + d / 2) / d;
		return k[0] ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [XW-1:0] series_value(logic mode,
			logic signed [XW-1:0] angle);
		longint x;
		longint y;
		longint h;
		longint r;
		int     terms;
		x     = angle;
		y     = x * x;
		terms = (mode == MODE_COS) ? 9 : 8;
		h     = series_coef(mode, terms - 1);
		for (int k = terms - 1; k > 0; k--)
			h = series_coef(mode, k - 1) + scaled_product(h, y, SQ_FRAC);
		if (mode == MODE_COS)
			r = scaled_product(h, 1, COEF_FRAC - OUT_FRAC);
		else
			r = scaled_product(x, h, COEF_FRAC);
		if (r > OUT_MAX)
			r = OUT_MAX;
		if (r < OUT_MIN)
			r = OUT_MIN;
		return r[XW-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// Clock and cycle guard
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Kill the run if the pipeline hangs or the stream never drains.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Result side: random back-pressure, then compare each transfer
	// ------------------------------------------------------------------------

	// Stall in roughly a quarter of the cycles unless a steady stretch runs.
	initial begin
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Sampling at the edge sees pre-edge values of the handshake and payload.
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (pending_values.size() == 0) begin
				$error("value: unexpected transfer, actual %h", result.value);
				mismatches++;
			end else begin
				if (result.value !== pending_values[0]) begin
					$error("value mismatch: expected %h, actual %h",
						pending_values[0], result.value);
					mismatches++;
				end
				void'(pending_values.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sample side
	// ------------------------------------------------------------------------

	// Offer one angle, optionally after idle cycles, and hold it until the
	// transfer. Valid stays high into the next call so back-to-back items
	// never see a low pulse.
	task automatic send_angle(logic mode, logic signed [XW-1:0] angle);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.mode  <= mode;
		sample.angle <= angle;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
		pending_values.push_back(series_value(mode, angle));
	endtask

	function automatic logic random_mode();
		return $urandom_range(0, 1) ? MODE_COS : MODE_SIN;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Zero, one LSB either side, the format extremes (including -4 exactly),
	// +-1, +-2, +pi/2 and -pi, each in both series.
	task automatic test_directed_angles();
		logic signed [XW-1:0] corners [11];
		corners = '{
			32'sh0000_0000, 32'sh0000_0001, -32'sh0000_0001,
			32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh2000_0000, -32'sh2000_0000,
			32'sh4000_0000, -32'sh4000_0000,
			32'sh3243_F6A9, -32'sh6487_ED51
		};
		foreach (corners[i]) begin
			send_angle(MODE_SIN, corners[i]);
			send_angle(MODE_COS, corners[i]);
		end
	endtask

	// Mixed mode, angles spread over the whole format, the principal range
	// and tiny magnitudes.
	task automatic test_random_angles(int count);
		logic signed [XW-1:0] a;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0, 1: a = $urandom;
				2: begin
					a = $urandom_range(0, 32'h6487_ED51);
					if ($urandom_range(0, 1))
						a = -a;
				end
				default: a = $signed($urandom_range(0, 4095)) - 2048;
			endcase
			send_angle(random_mode(), a);
		end
	endtask

	// Long back-to-back stream with no idling on either side.
	task automatic test_steady_stream(int count);
		steady = 1'b1;
		for (int i = 0; i < count; i++)
			send_angle(random_mode(), $urandom);
		steady = 1'b0;
	endtask

	// Angles close to both ends of the format, where the series terms are
	// largest and any loss of width in the products would show.
	task automatic test_edge_angles(int count);
		logic signed [XW-1:0] a;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1))
				a = 32'sh7FFF_FFFF - $signed($urandom_range(0, 65535));
			else
				a = 32'sh8000_0000 + $signed($urandom_range(0, 65535));
			send_angle(random_mode(), a);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		mismatches = 0;
		cycles     = 0;
		steady     = 1'b0;
		arst_n       <= 1'b0;
		sample.valid <= 1'b0;
		sample.mode  <= MODE_SIN;
		sample.angle <= '0;

		// Hold reset, then release it on an edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_angles();
		test_random_angles(300);
		test_steady_stream(150);
		test_edge_angles(150);

		// Drop valid once the last transfer is in.
		sample.valid <= 1'b0;

		// Drain, then linger a while to catch stray results.
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);

		if (pending_values.size() != 0) begin
			$error("value: %0d results never arrived", pending_values.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
